// ----- sv/ctc_pkg.sv -----
package ctc_pkg;

	localparam int VEC_BITS   = 20;
	localparam int QUAT_BITS  = 15;
	localparam int VEC_FRAC   = VEC_BITS / 2;
	localparam int QUAT_FRAC  = QUAT_BITS - 2;
	localparam int FIELD_BITS = 60;
	// register stages from input transfer to output register
	localparam int PIPE_DEPTH = 6;

	// uv = u x v: 15x20 products, difference of two
	localparam int UV_BITS  = QUAT_BITS + VEC_BITS + 1;
	// uuv = u x uv: difference of two 15xUV products
	localparam int UUV_BITS = QUAT_BITS + UV_BITS + 1;
	// exact rotation accumulator with 2*QUAT_FRAC + VEC_FRAC fraction bits
	localparam int ACC_BITS = UUV_BITS + 3;
	// Hamilton sum of four 15x15 products
	localparam int HAM_BITS = 2 * QUAT_BITS + 2;
	localparam int VP_BITS  = 2 * VEC_BITS;

	typedef logic signed [VEC_BITS-1:0]  vec_t;
	typedef logic signed [QUAT_BITS-1:0] quat_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] parent_scale;
		logic [FIELD_BITS-1:0] parent_rotation;
		logic [FIELD_BITS-1:0] parent_position;
		logic [FIELD_BITS-1:0] child_scale;
		logic [FIELD_BITS-1:0] child_rotation;
		logic [FIELD_BITS-1:0] child_position;
	} in_item_t;

	typedef struct packed {
		logic signed [VEC_BITS-1:0] peak_scale;
		logic [FIELD_BITS-1:0]      global_scale;
		logic [FIELD_BITS-1:0]      global_rotation;
		logic [FIELD_BITS-1:0]      global_position;
	} out_item_t;

	function automatic vec_t vslice(input logic [FIELD_BITS-1:0] w, input int idx);
		vslice = vec_t'(w >> (idx * VEC_BITS));
	endfunction

	function automatic quat_t qslice(input logic [FIELD_BITS-1:0] w, input int idx);
		qslice = quat_t'(w >> (idx * QUAT_BITS));
	endfunction

	// saturate a signed value (up to 80 bits) to VEC_BITS
	function automatic vec_t sat_vec(input logic signed [79:0] x);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = (80'sd1 <<< (VEC_BITS - 1)) - 80'sd1;
		lo = -hi - 80'sd1;
		if (x > hi)
			sat_vec = vec_t'(hi);
		else if (x < lo)
			sat_vec = vec_t'(lo);
		else
			sat_vec = vec_t'(x);
	endfunction

	function automatic quat_t sat_quat(input logic signed [79:0] x);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = (80'sd1 <<< (QUAT_BITS - 1)) - 80'sd1;
		lo = -hi - 80'sd1;
		if (x > hi)
			sat_quat = quat_t'(hi);
		else if (x < lo)
			sat_quat = quat_t'(lo);
		else
			sat_quat = quat_t'(x);
	endfunction

endpackage

// ----- sv/ctc_rotate.sv -----
// Rotation datapath: four register stages, two layers of narrow multiplies, then accumulate and saturate.
module ctc_rotate (
	input  logic                  clk,
	input  logic                  en,
	input  ctc_pkg::quat_t        pq [4],
	input  ctc_pkg::vec_t         lp [3],
	output ctc_pkg::vec_t         rot_s4 [3]
);

	logic signed [ctc_pkg::UV_BITS-1:0]  uv_s1 [3];
	ctc_pkg::quat_t                      pq_s1 [4];
	ctc_pkg::vec_t                       lp_s1 [3];
	logic signed [ctc_pkg::ACC_BITS-1:0] wuv_s2 [3];
	logic signed [ctc_pkg::UUV_BITS-1:0] uuv_s2 [3];
	ctc_pkg::vec_t                       lp_s2 [3];
	logic signed [ctc_pkg::ACC_BITS-1:0] acc_s3 [3];

	// stage 1: u x v
	always_ff @(posedge clk) begin
		if (en) begin
			uv_s1[0] <= ctc_pkg::UV_BITS'(pq[2] * lp[2]) - ctc_pkg::UV_BITS'(pq[3] * lp[1]);
			uv_s1[1] <= ctc_pkg::UV_BITS'(pq[3] * lp[0]) - ctc_pkg::UV_BITS'(pq[1] * lp[2]);
			uv_s1[2] <= ctc_pkg::UV_BITS'(pq[1] * lp[1]) - ctc_pkg::UV_BITS'(pq[2] * lp[0]);
			pq_s1    <= pq;
			lp_s1    <= lp;
		end
	end

	// stage 2: u x (u x v) and w * (u x v)
	always_ff @(posedge clk) begin
		if (en) begin
			uuv_s2[0] <= ctc_pkg::UUV_BITS'(pq_s1[2] * uv_s1[2])
				- ctc_pkg::UUV_BITS'(pq_s1[3] * uv_s1[1]);
			uuv_s2[1] <= ctc_pkg::UUV_BITS'(pq_s1[3] * uv_s1[0])
				- ctc_pkg::UUV_BITS'(pq_s1[1] * uv_s1[2]);
			uuv_s2[2] <= ctc_pkg::UUV_BITS'(pq_s1[1] * uv_s1[1])
				- ctc_pkg::UUV_BITS'(pq_s1[2] * uv_s1[0]);
			for (int i = 0; i < 3; i++)
				wuv_s2[i] <= ctc_pkg::ACC_BITS'(pq_s1[0] * uv_s1[i]);
			lp_s2 <= lp_s1;
		end
	end

	// stage 3: exact accumulate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				acc_s3[i] <= (ctc_pkg::ACC_BITS'(lp_s2[i]) <<< (2 * ctc_pkg::QUAT_FRAC))
					+ ((wuv_s2[i] + ctc_pkg::ACC_BITS'(uuv_s2[i])) <<< 1);
		end
	end

	// stage 4: floor and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				rot_s4[i] <= ctc_pkg::sat_vec(80'(acc_s3[i] >>> (2 * ctc_pkg::QUAT_FRAC)));
		end
	end

endmodule

// ----- sv/child_transform_compose.sv -----
// Channel | Direction | Handshake      | Payload
// in      | input     | valid / stall  | in_item_t (two transforms)
// out     | output    | valid / stall  | out_item_t (global transform)
//
// One item per cycle while out is not stalled.
// Depth is set by the rotation chain: u x v, u x uv, accumulate, floor, scale, offset.
// Reset clears only the valid bits of every stage.
// A stall on out freezes the whole pipe while out holds data; in stall is out stall while out holds data.
module child_transform_compose (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ctc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ctc_pkg::out_item_t out_data
);

	logic                           en;
	logic [ctc_pkg::PIPE_DEPTH-1:0] v_q;
	ctc_pkg::quat_t      pq [4];
	ctc_pkg::quat_t      lq [4];
	ctc_pkg::vec_t       lp [3];
	ctc_pkg::vec_t       rot_s4 [3];

	// side data carried alongside the rotation chain
	ctc_pkg::vec_t       ps_s1 [3], ps_s2 [3], ps_s3 [3], ps_s4 [3];
	ctc_pkg::vec_t       pp_s1 [3], pp_s2 [3], pp_s3 [3], pp_s4 [3], pp_s5 [3];
	ctc_pkg::vec_t       gs_s1 [3], gs_s2 [3], gs_s3 [3], gs_s4 [3], gs_s5 [3];
	logic signed [ctc_pkg::HAM_BITS-1:0] ham_s1 [4];
	ctc_pkg::quat_t      gq_s2 [4], gq_s3 [4], gq_s4 [4], gq_s5 [4];
	ctc_pkg::vec_t       sr_s5 [3];
	ctc_pkg::out_item_t  out_s6;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_q[ctc_pkg::PIPE_DEPTH-1];
	assign out_data  = out_s6;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pq[i] = ctc_pkg::qslice(in_data.parent_rotation, i);
			lq[i] = ctc_pkg::qslice(in_data.child_rotation, i);
		end
		for (int i = 0; i < 3; i++)
			lp[i] = ctc_pkg::vslice(in_data.child_position, i);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[ctc_pkg::PIPE_DEPTH-2:0], in_valid};
		end
	end

	ctc_rotate u_rot (
		.clk    (clk),
		.en     (en),
		.pq     (pq),
		.lp     (lp),
		.rot_s4 (rot_s4)
	);

	// stage 1: Hamilton products, scale products
	always_ff @(posedge clk) begin
		if (en) begin
			ham_s1[0] <= ctc_pkg::HAM_BITS'(pq[0] * lq[0]) - ctc_pkg::HAM_BITS'(pq[1] * lq[1])
				- ctc_pkg::HAM_BITS'(pq[2] * lq[2]) - ctc_pkg::HAM_BITS'(pq[3] * lq[3]);
			ham_s1[1] <= ctc_pkg::HAM_BITS'(pq[0] * lq[1]) + ctc_pkg::HAM_BITS'(pq[1] * lq[0])
				+ ctc_pkg::HAM_BITS'(pq[2] * lq[3]) - ctc_pkg::HAM_BITS'(pq[3] * lq[2]);
			ham_s1[2] <= ctc_pkg::HAM_BITS'(pq[0] * lq[2]) - ctc_pkg::HAM_BITS'(pq[1] * lq[3])
				+ ctc_pkg::HAM_BITS'(pq[2] * lq[0]) + ctc_pkg::HAM_BITS'(pq[3] * lq[1]);
			ham_s1[3] <= ctc_pkg::HAM_BITS'(pq[0] * lq[3]) + ctc_pkg::HAM_BITS'(pq[1] * lq[2])
				- ctc_pkg::HAM_BITS'(pq[2] * lq[1]) + ctc_pkg::HAM_BITS'(pq[3] * lq[0]);
			for (int i = 0; i < 3; i++) begin
				ps_s1[i] <= ctc_pkg::vslice(in_data.parent_scale, i);
				pp_s1[i] <= ctc_pkg::vslice(in_data.parent_position, i);
				gs_s1[i] <= ctc_pkg::sat_vec(80'((ctc_pkg::VP_BITS'(
					ctc_pkg::vslice(in_data.child_scale, i))
					* ctc_pkg::VP_BITS'(ctc_pkg::vslice(in_data.parent_scale, i)))
					>>> ctc_pkg::VEC_FRAC));
			end
		end
	end

	// stages 2-5: quaternion rounding, carry side data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				gq_s2[i] <= ctc_pkg::sat_quat(80'(ham_s1[i] >>> ctc_pkg::QUAT_FRAC));
				gq_s3[i] <= gq_s2[i];
				gq_s4[i] <= gq_s3[i];
				gq_s5[i] <= gq_s4[i];
			end
			ps_s2 <= ps_s1; ps_s3 <= ps_s2; ps_s4 <= ps_s3;
			pp_s2 <= pp_s1; pp_s3 <= pp_s2; pp_s4 <= pp_s3; pp_s5 <= pp_s4;
			gs_s2 <= gs_s1; gs_s3 <= gs_s2; gs_s4 <= gs_s3; gs_s5 <= gs_s4;
		end
	end

	// stage 5: scale the rotated position
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sr_s5[i] <= ctc_pkg::sat_vec(80'((ctc_pkg::VP_BITS'(rot_s4[i])
					* ctc_pkg::VP_BITS'(ps_s4[i])) >>> ctc_pkg::VEC_FRAC));
		end
	end

	// stage 6: offset, pack, max scale
	always_ff @(posedge clk) begin
		if (en) begin
			out_s6.global_position <= {
				ctc_pkg::sat_vec(80'(sr_s5[2]) + 80'(pp_s5[2])),
				ctc_pkg::sat_vec(80'(sr_s5[1]) + 80'(pp_s5[1])),
				ctc_pkg::sat_vec(80'(sr_s5[0]) + 80'(pp_s5[0]))};
			out_s6.global_rotation <= {gq_s5[3], gq_s5[2], gq_s5[1], gq_s5[0]};
			out_s6.global_scale    <= {gs_s5[2], gs_s5[1], gs_s5[0]};
			if (gs_s5[2] > gs_s5[1] && gs_s5[2] > gs_s5[0])
				out_s6.peak_scale <= gs_s5[2];
			else if (gs_s5[1] > gs_s5[0])
				out_s6.peak_scale <= gs_s5[1];
			else
				out_s6.peak_scale <= gs_s5[0];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && in_valid |=> v_q[0])
		else $error("accepted item lost");

endmodule

// ----- bench/child_transform_compose_checker.sv -----
`timescale 1ns / 100ps

module child_transform_compose_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  ctc_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  ctc_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending_count
);

	ctc_pkg::out_item_t expected_globals[$];

	function automatic longint sx(input logic [59:0] w, input int idx, input int bits);
		logic [63:0] v;
		v = 64'(w) >> (idx * bits);
		v = v & ((64'd1 << bits) - 64'd1);
		if (v[bits-1])
			return longint'(v) - (longint'(1) << bits);
		return longint'(v);
	endfunction

	// floor division by a power of two
	function automatic longint fshift(input longint x, input int s);
		return x >>> s;
	endfunction

	function automatic longint clamp(input longint x, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function automatic longint scale_mul(input longint a, input longint b);
		return clamp(fshift(a * b, ctc_pkg::VEC_FRAC), ctc_pkg::VEC_BITS);
	endfunction

	function automatic ctc_pkg::out_item_t compose_transform(input ctc_pkg::in_item_t t);
		longint lp[3], ls[3], pp[3], ps[3], lq[4], pq[4];
		longint uv[3], uuv[3], gs[3], gq[4];
		longint acc, rot, mx;
		ctc_pkg::out_item_t r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			lp[i] = sx(t.child_position, i, ctc_pkg::VEC_BITS);
			ls[i] = sx(t.child_scale, i, ctc_pkg::VEC_BITS);
			pp[i] = sx(t.parent_position, i, ctc_pkg::VEC_BITS);
			ps[i] = sx(t.parent_scale, i, ctc_pkg::VEC_BITS);
		end
		for (int i = 0; i < 4; i++) begin
			lq[i] = sx(t.child_rotation, i, ctc_pkg::QUAT_BITS);
			pq[i] = sx(t.parent_rotation, i, ctc_pkg::QUAT_BITS);
		end
		// rotate local position by parent quaternion
		uv[0] = pq[2] * lp[2] - pq[3] * lp[1];
		uv[1] = pq[3] * lp[0] - pq[1] * lp[2];
		uv[2] = pq[1] * lp[1] - pq[2] * lp[0];
		uuv[0] = pq[2] * uv[2] - pq[3] * uv[1];
		uuv[1] = pq[3] * uv[0] - pq[1] * uv[2];
		uuv[2] = pq[1] * uv[1] - pq[2] * uv[0];
		for (int i = 0; i < 3; i++) begin
			acc = lp[i] * (longint'(1) <<< (2 * ctc_pkg::QUAT_FRAC))
				+ 2 * (uv[i] * pq[0] + uuv[i]);
			rot = clamp(fshift(acc, 2 * ctc_pkg::QUAT_FRAC), ctc_pkg::VEC_BITS);
			r.global_position[i*ctc_pkg::VEC_BITS +: ctc_pkg::VEC_BITS] =
				ctc_pkg::VEC_BITS'(clamp(scale_mul(rot, ps[i]) + pp[i],
				ctc_pkg::VEC_BITS));
			gs[i] = scale_mul(ls[i], ps[i]);
			r.global_scale[i*ctc_pkg::VEC_BITS +: ctc_pkg::VEC_BITS] =
				ctc_pkg::VEC_BITS'(gs[i]);
		end
		// Hamilton product parent * local
		gq[0] = pq[0] * lq[0] - pq[1] * lq[1] - pq[2] * lq[2] - pq[3] * lq[3];
		gq[1] = pq[0] * lq[1] + pq[1] * lq[0] + pq[2] * lq[3] - pq[3] * lq[2];
		gq[2] = pq[0] * lq[2] - pq[1] * lq[3] + pq[2] * lq[0] + pq[3] * lq[1];
		gq[3] = pq[0] * lq[3] + pq[1] * lq[2] - pq[2] * lq[1] + pq[3] * lq[0];
		for (int i = 0; i < 4; i++)
			r.global_rotation[i*ctc_pkg::QUAT_BITS +: ctc_pkg::QUAT_BITS] =
				ctc_pkg::QUAT_BITS'(clamp(fshift(gq[i], ctc_pkg::QUAT_FRAC),
				ctc_pkg::QUAT_BITS));
		mx = gs[0];
		if (gs[1] > mx)
			mx = gs[1];
		if (gs[2] > mx)
			mx = gs[2];
		r.peak_scale = 20'(mx);
		return r;
	endfunction

	assign pending_count = expected_globals.size();

	// predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		ctc_pkg::out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_globals = {expected_globals, compose_transform(in_data)};
			if (out_valid && !out_stall) begin
				if (expected_globals.size() == 0) begin
					$error("unexpected result transfer %h", out_data);
					fail_count++;
				end else begin
					want = expected_globals.pop_front();
					if (out_data.global_position !== want.global_position) begin
						$error("global_position expected %h actual %h",
							want.global_position, out_data.global_position);
						fail_count++;
					end
					if (out_data.global_rotation !== want.global_rotation) begin
						$error("global_rotation expected %h actual %h",
							want.global_rotation, out_data.global_rotation);
						fail_count++;
					end
					if (out_data.global_scale !== want.global_scale) begin
						$error("global_scale expected %h actual %h",
							want.global_scale, out_data.global_scale);
						fail_count++;
					end
					if (out_data.peak_scale !== want.peak_scale) begin
						$error("peak_scale expected %0d actual %0d",
							want.peak_scale, out_data.peak_scale);
						fail_count++;
					end
				end
			end
		end
	end

	initial fail_count = 0;

endmodule

// ----- bench/child_transform_compose_tb.sv -----
`timescale 1ns / 100ps

module child_transform_compose_tb;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	ctc_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	ctc_pkg::out_item_t out_data;
	int                 fail_count;
	int                 pending_count;
	int                 cycle_count;
	bit                 hold_off;
	bit                 calm;

	child_transform_compose dut (.*);

	child_transform_compose_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic [59:0] rand60();
		return 60'({$urandom(), $urandom()});
	endfunction

	// near-unit quaternion component or random raw bits
	function automatic logic [14:0] qcomp();
		case ($urandom_range(0, 3))
			0: return 15'($signed($urandom_range(0, 16384)) - 8192);
			1: return 15'h2000;
			default: return 15'($urandom());
		endcase
	endfunction

	function automatic logic [19:0] vcomp();
		case ($urandom_range(0, 4))
			0: return 20'h7ffff;
			1: return 20'h80000;
			2: return 20'($signed($urandom_range(0, 8192)) - 4096);
			default: return 20'($urandom());
		endcase
	endfunction

	function automatic ctc_pkg::in_item_t random_transform();
		ctc_pkg::in_item_t t;
		if ($urandom_range(0, 9) == 0)
			return {rand60(), rand60(), rand60(), rand60(), rand60(), rand60()};
		t.child_position  = {vcomp(), vcomp(), vcomp()};
		t.child_scale     = {vcomp(), vcomp(), vcomp()};
		t.parent_position = {vcomp(), vcomp(), vcomp()};
		t.parent_scale    = {vcomp(), vcomp(), vcomp()};
		t.child_rotation  = {qcomp(), qcomp(), qcomp(), qcomp()};
		t.parent_rotation = {qcomp(), qcomp(), qcomp(), qcomp()};
		return t;
	endfunction

	task automatic send(input ctc_pkg::in_item_t t);
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do @(posedge clk); while (in_stall);
	endtask

	// receiver stall: random, with a long hold-off and a calm stretch
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 8);
		end
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 200000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		ctc_pkg::in_item_t t;
		logic [59:0] ones;
		ones      = '1;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		hold_off  = 0;
		calm      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zeros, all ones, identity, extremes, non-unit quaternions
		send('0);
		send({6{ones}});
		t = '0;
		t.child_rotation  = 60'h2000;
		t.parent_rotation = 60'h2000;
		t.child_scale     = {3{20'h00400}};
		t.parent_scale    = {3{20'h00400}};
		t.child_position  = {20'h00c00, 20'hff800, 20'h00400};
		send(t);
		send({6{60'h7ffff7ffff7ffff}});
		send({6{60'h800008000080000}});
		t.parent_rotation = {4{15'h3fff}};
		t.parent_scale    = {3{20'h7ffff}};
		t.child_position  = {3{20'h7ffff}};
		send(t);
		t.parent_rotation = {4{15'h4000}};
		t.child_rotation  = {4{15'h4000}};
		t.child_position  = {3{20'h80000}};
		t.parent_position = {3{20'h80000}};
		send(t);
		t.parent_rotation = {15'h0, 15'h0, 15'h0, 15'h6000};
		t.child_scale     = {20'h80000, 20'h7ffff, 20'h00001};
		t.parent_scale    = {20'h80000, 20'h80000, 20'hfffff};
		send(t);
		for (int i = 0; i < 12; i++)
			send(random_transform());

		// fill the pipe against a long receiver hold-off
		hold_off = 1;
		for (int i = 0; i < 40; i++)
			send(random_transform());
		for (int i = 0; i < 1000; i++) begin
			calm = (i >= 300 && i < 450);
			if (i == 600) begin
				in_valid <= 1'b0;
				while (pending_count != 0) @(posedge clk);
			end
			send(random_transform());
		end
		calm = 0;
		in_valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
